// ===== design/vec4_mat4_transform_defines.svh =====
// Assertion macros used by the port-level checker of the vector transform block.
`ifndef VEC4_MAT4_TRANSFORM_DEFINES_SVH
`define VEC4_MAT4_TRANSFORM_DEFINES_SVH

// Checked at every rising clock edge outside of reset.
`define VMT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define VMT_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/vmt_pkg.sv =====
// Types, constants and single-precision arithmetic steps of the vector transform block.
package vmt_pkg;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] INF  = 32'h7F80_0000;

    localparam logic [63:0] CFG_RESET [0:7] = '{
        64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000
    };

    typedef logic signed [10:0] exp_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_bits;
        logic        sign;
        exp_t        e;
        logic [63:0] s;
    } unp_t;

    typedef struct packed {
        unp_t       u;
        logic [5:0] lz;
    } norm_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_bits;
        logic        sign;
        logic        ovf;
        logic        subn;
        logic [7:0]  expf;
        logic [63:0] t;
        logic        sticky;
    } sh_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_bits;
        logic        sign;
        logic        sub;
        exp_t        e;
        logic [63:0] x;
        logic [63:0] y;
    } al_t;

    function automatic logic is_nan(input logic [31:0] a);
        return a[30:0] > INF[30:0];
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return a[30:0] == INF[30:0];
    endfunction

    function automatic logic [23:0] unp_m(input logic [31:0] a);
        return {|a[30:23], a[22:0]};
    endfunction

    function automatic exp_t unp_e(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? exp_t'(1) : exp_t'({3'b000, a[30:23]});
    endfunction

    // Exact product with its exponent, or the finished bits of a special case.
    function automatic unp_t fmul_f(input logic [31:0] a, input logic [31:0] b);
        unp_t        r;
        logic [47:0] p;
        r = '0;
        r.sign = a[31] ^ b[31];
        p = unp_m(a) * unp_m(b);
        if (is_nan(a) || is_nan(b)) begin
            r.spec = 1'b1;
            r.spec_bits = QNAN;
        end else if (is_inf(a) || is_inf(b)) begin
            r.spec = 1'b1;
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
                r.spec_bits = QNAN;
            else
                r.spec_bits = {r.sign, INF[30:0]};
        end else if (p == 48'd0) begin
            r.spec = 1'b1;
            r.spec_bits = {r.sign, 31'd0};
        end else begin
            r.e = unp_e(a) + unp_e(b) - exp_t'(300);
            r.s = {16'd0, p};
        end
        return r;
    endfunction

    // Operand swap and alignment of the smaller addend with a sticky bit.
    function automatic al_t fadd_align(input logic [31:0] a_in, input logic [31:0] b_in);
        al_t         r;
        logic [31:0] a;
        logic [31:0] b;
        logic [7:0]  d;
        logic [63:0] yb;
        r = '0;
        a = a_in;
        b = b_in;
        if (a_in[30:0] < b_in[30:0]) begin
            a = b_in;
            b = a_in;
        end
        d = 8'(unp_e(a) - unp_e(b));
        yb = {1'b0, unp_m(b), 39'd0};
        r.sign = a[31];
        r.sub = a[31] ^ b[31];
        r.e = unp_e(a) - exp_t'(189);
        r.x = {1'b0, unp_m(a), 39'd0};
        if (d >= 8'd63)
            r.y = {63'd0, |unp_m(b)};
        else
            r.y = (yb >> d) | {63'd0, |(yb & ((64'd1 << d) - 64'd1))};
        if (is_nan(a_in) || is_nan(b_in)) begin
            r.spec = 1'b1;
            r.spec_bits = QNAN;
        end else if (is_inf(a_in) && is_inf(b_in)) begin
            r.spec = 1'b1;
            r.spec_bits = (a_in[31] ^ b_in[31]) ? QNAN : a_in;
        end else if (is_inf(a_in)) begin
            r.spec = 1'b1;
            r.spec_bits = a_in;
        end else if (is_inf(b_in)) begin
            r.spec = 1'b1;
            r.spec_bits = b_in;
        end
        return r;
    endfunction

    function automatic unp_t fadd_sum(input al_t a);
        unp_t        r;
        logic [63:0] s;
        r = '0;
        s = a.sub ? (a.x - a.y) : (a.x + a.y);
        r.spec = a.spec;
        r.spec_bits = a.spec_bits;
        r.sign = a.sign;
        r.e = a.e;
        r.s = s;
        if (!a.spec && s == 64'd0) begin
            r.spec = 1'b1;
            r.spec_bits = a.sub ? 32'd0 : {a.sign, 31'd0};
        end
        return r;
    endfunction

    function automatic norm_t lzc_f(input unp_t u);
        norm_t r;
        r.u = u;
        r.lz = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (u.s[i])
                r.lz = 6'(63 - i);
        end
        return r;
    endfunction

    // Places the kept significand in bits 63..40, for normal and subnormal results.
    function automatic sh_t shift_f(input norm_t n);
        sh_t  r;
        exp_t be;
        exp_t net;
        exp_t rs;
        r = '0;
        be = n.u.e + exp_t'(190) - exp_t'({5'd0, n.lz});
        net = n.u.e + exp_t'(189);
        rs = -net;
        r.spec = n.u.spec;
        r.spec_bits = n.u.spec_bits;
        r.sign = n.u.sign;
        r.ovf = be >= exp_t'(255);
        r.subn = be < exp_t'(1);
        r.expf = 8'(be - exp_t'(1));
        if (!r.subn) begin
            r.t = n.u.s << n.lz;
        end else if (net >= exp_t'(0)) begin
            r.t = n.u.s << net[5:0];
        end else if (rs >= exp_t'(64)) begin
            r.t = 64'd0;
            r.sticky = |n.u.s;
        end else begin
            r.t = n.u.s >> rs[5:0];
            r.sticky = |(n.u.s & ((64'd1 << rs[5:0]) - 64'd1));
        end
        return r;
    endfunction

    function automatic logic [31:0] round_f(input sh_t r);
        logic [23:0] q;
        logic        up;
        logic [31:0] res;
        q = r.t[63:40];
        up = r.t[39] & ((|r.t[38:0]) | r.sticky | q[0]);
        if (r.spec)
            res = r.spec_bits;
        else if (r.ovf)
            res = {r.sign, INF[30:0]};
        else if (r.subn)
            res = {r.sign, 31'({7'd0, q}) + 31'({30'd0, up})};
        else
            res = {r.sign, {r.expf, 23'd0} + 31'({7'd0, q}) + 31'({30'd0, up})};
        return res;
    endfunction

endpackage

// ===== design/vec4_mat4_transform.sv =====
// Top level: pipelined row vector times 4x4 single-precision matrix.
//
//  Channel  Direction  Beat contents
//  s_*      in         in_x, in_y, in_z, in_w (32 bits each, x lowest)
//  m_*      out        out_x, out_y, out_z, out_w (32 bits each, x lowest)
//  cfg_*    in         matrix register write, index 0..7, 64-bit data
//
// One beat enters per cycle unless the output stalls; it passes four stages for the
// multipliers, then five for each of the three chained adders per lane.
// The whole pipeline advances together; it holds while a result waits at the output.
// Reset clears the valid bits and loads the identity matrix.
module vec4_mat4_transform (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // in_x, in_y, in_z, in_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // out_x, out_y, out_z, out_w
);
    import vmt_pkg::*;

    localparam int NST = 19;

    logic [63:0]    mat_reg   [8];
    logic [31:0]    m_ent     [4][4];
    logic [31:0]    vin       [4];
    unp_t           mul_reg   [4][4];
    norm_t          mnorm_reg [4][4];
    sh_t            msh_reg   [4][4];
    logic [31:0]    prod_reg  [4][4];
    al_t            al_reg    [3][4];
    unp_t           sum_reg   [3][4];
    norm_t          snorm_reg [3][4];
    sh_t            ssh_reg   [3][4];
    logic [31:0]    acc_reg   [3][4];
    logic [31:0]    dl2_reg   [4][5];
    logic [31:0]    dl3_reg   [4][10];
    logic [31:0]    opa       [3][4];
    logic [31:0]    opb       [3][4];
    logic [NST-1:0] vld_reg;
    logic           adv;

    assign adv = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata = {acc_reg[2][3], acc_reg[2][2], acc_reg[2][1], acc_reg[2][0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                mat_reg[i] <= CFG_RESET[i];
        end
        else if (cfg_we)
        begin
            mat_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            vin[r] = s_tdata[32*r +: 32];
            for (int c = 0; c < 4; c++)
            begin
                if ((c & 1) != 0)
                    m_ent[r][c] = mat_reg[3'(2 * r + (c >> 1))][63:32];
                else
                    m_ent[r][c] = mat_reg[3'(2 * r + (c >> 1))][31:0];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            opa[0][c] = prod_reg[c][0];
            opa[1][c] = acc_reg[0][c];
            opa[2][c] = acc_reg[1][c];
            opb[0][c] = prod_reg[c][1];
            opb[1][c] = dl2_reg[c][4];
            opb[2][c] = dl3_reg[c][9];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    mul_reg[c][r]   <= fmul_f(m_ent[r][c], vin[r]);
                    mnorm_reg[c][r] <= lzc_f(mul_reg[c][r]);
                    msh_reg[c][r]   <= shift_f(mnorm_reg[c][r]);
                    prod_reg[c][r]  <= round_f(msh_reg[c][r]);
                end
                dl2_reg[c][0] <= prod_reg[c][2];
                for (int j = 1; j < 5; j++)
                    dl2_reg[c][j] <= dl2_reg[c][j-1];
                dl3_reg[c][0] <= prod_reg[c][3];
                for (int j = 1; j < 10; j++)
                    dl3_reg[c][j] <= dl3_reg[c][j-1];
                for (int k = 0; k < 3; k++)
                begin
                    al_reg[k][c]    <= fadd_align(opa[k][c], opb[k][c]);
                    sum_reg[k][c]   <= fadd_sum(al_reg[k][c]);
                    snorm_reg[k][c] <= lzc_f(sum_reg[k][c]);
                    ssh_reg[k][c]   <= shift_f(snorm_reg[k][c]);
                    acc_reg[k][c]   <= round_f(ssh_reg[k][c]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

endmodule

// ===== design/vmt_checker.sv =====
// Port-level checker for the vector transform block and its bind.
`include "vec4_mat4_transform_defines.svh"

module vmt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    `VMT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")
    `VMT_ASSERT(a_stall_blocks_in, m_tvalid && !m_tready |-> !s_tready, "input taken while the pipeline is stalled")
    `VMT_ASSERT(a_empty_takes_in, !m_tvalid |-> s_tready, "input refused with no result waiting")
    `VMT_ASSERT_ANY(a_reset_quiet, !rst_n |-> !m_tvalid, "result shown during reset")

endmodule

bind vec4_mat4_transform vmt_checker u_vmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/vec4_mat4_transform_checker.sv =====
// Checker for the vector transform block: predicts each output beat and compares it.
`timescale 1ns / 100ps
module vec4_mat4_transform_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    output int           errors,
    output int           pending
);
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_INF  = 32'h7F80_0000;
    localparam logic [31:0] FP_SIGN = 32'h8000_0000;

    logic [63:0]  matrix [0:7];
    logic [127:0] expected_vectors [$];

    function automatic logic fp_nan(input logic [31:0] a);
        return a[30:0] > FP_INF[30:0];
    endfunction

    function automatic logic fp_inf(input logic [31:0] a);
        return a[30:0] == FP_INF[30:0];
    endfunction

    function automatic logic [63:0] mant(input logic [31:0] a);
        return {40'd0, a[30:23] != 8'd0, a[22:0]};
    endfunction

    function automatic int expo(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    endfunction

    function automatic logic [31:0] round_pack(input logic [31:0] sign, input int e_in,
                                               input logic [63:0] s_in);
        logic [63:0] s;
        int          e;
        int          be;
        int          sh;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        s = s_in;
        e = e_in;
        while (s[63] == 1'b0)
        begin
            s = s << 1;
            e--;
        end
        be = e + 63 + 127;
        if (be >= 255)
            return sign | FP_INF;
        if (be >= 1)
            sh = 40;
        else if (41 - be > 64)
            return sign;
        else
            sh = 41 - be;
        if (sh < 64)
        begin
            q = s >> sh;
            rem = s & ((64'd1 << sh) - 64'd1);
        end
        else
        begin
            q = 64'd0;
            rem = s;
        end
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q++;
        if (be >= 1)
            return sign | ((32'(be - 1) << 23) + q[31:0]);
        return sign | q[31:0];
    endfunction

    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] sign;
        logic [63:0] p;
        sign = (a ^ b) & FP_SIGN;
        if (fp_nan(a) || fp_nan(b))
            return FP_QNAN;
        if (fp_inf(a) || fp_inf(b))
        begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
                return FP_QNAN;
            return sign | FP_INF;
        end
        p = mant(a) * mant(b);
        if (p == 64'd0)
            return sign;
        return round_pack(sign, expo(a) + expo(b) - 300, p);
    endfunction

    function automatic logic [31:0] sp_add(input logic [31:0] a_in, input logic [31:0] b_in);
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] s;
        int          d;
        a = a_in;
        b = b_in;
        if (fp_nan(a) || fp_nan(b))
            return FP_QNAN;
        if (fp_inf(a) && fp_inf(b))
            return (a[31] ^ b[31]) ? FP_QNAN : a;
        if (fp_inf(a))
            return a;
        if (fp_inf(b))
            return b;
        if (a[30:0] < b[30:0])
        begin
            a = b_in;
            b = a_in;
        end
        x = mant(a) << 39;
        y = mant(b) << 39;
        d = expo(a) - expo(b);
        if (d >= 63)
            y = {63'd0, mant(b) != 64'd0};
        else if (d > 0)
            y = (y >> d) | {63'd0, (y & ((64'd1 << d) - 64'd1)) != 64'd0};
        s = (a[31] == b[31]) ? x + y : x - y;
        if (s == 64'd0)
            return (a[31] == b[31]) ? (a & FP_SIGN) : 32'd0;
        return round_pack(a & FP_SIGN, expo(a) - 189, s);
    endfunction

    function automatic logic [31:0] coeff(input int row, input int col);
        logic [63:0] r;
        r = matrix[row * 2 + col / 2];
        return (col % 2) ? r[63:32] : r[31:0];
    endfunction

    function automatic logic [127:0] transform(input logic [127:0] v);
        logic [127:0] res;
        logic [31:0]  acc;
        for (int c = 0; c < 4; c++)
        begin
            acc = sp_mul(coeff(0, c), v[31:0]);
            for (int r = 1; r < 4; r++)
                acc = sp_add(acc, sp_mul(coeff(r, c), v[32*r +: 32]));
            res[32*c +: 32] = acc;
        end
        return res;
    endfunction

    assign pending = expected_vectors.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] exp_v;
        if (!rst_n)
        begin
            errors <= 0;
            expected_vectors.delete();
            matrix[0] = 64'h0000_0000_3F80_0000;
            matrix[1] = 64'h0;
            matrix[2] = 64'h3F80_0000_0000_0000;
            matrix[3] = 64'h0;
            matrix[4] = 64'h0;
            matrix[5] = 64'h0000_0000_3F80_0000;
            matrix[6] = 64'h0;
            matrix[7] = 64'h3F80_0000_0000_0000;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_vectors.size() == 0)
                begin
                    if (errors < 10)
                        $display("Unexpected output beat %h", m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_v = expected_vectors.pop_front();
                    if (exp_v !== m_tdata)
                    begin
                        if (errors < 10)
                            $display("Mismatch: expected %h, actual %h", exp_v, m_tdata);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_vectors.push_back(transform(s_tdata));
            if (cfg_we)
                matrix[cfg_index] = cfg_wdata;
        end
    end
endmodule

// ===== tb/vec4_mat4_transform_tb.sv =====
// Testbench top: drives vectors and matrix writes into the transform block and gives the verdict.
`timescale 1ns / 100ps
module vec4_mat4_transform_tb;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [30:0] FP_INF_LOW = 31'h7F80_0000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    int           errors;
    int           pending;
    int           idle_cycles;
    logic         hold_off;
    logic         burst_phase;

    vec4_mat4_transform u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    vec4_mat4_transform_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] random_float();
        logic [31:0] f;
        int          k;
        k = $urandom_range(0, 19);
        f = $urandom;
        case (k)
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'h00;
            2: f[30:0] = 31'd0;
            3: f[30:0] = FP_INF_LOW;
            4: f[30:23] = 8'($urandom_range(0, 30));
            5: f[30:23] = 8'($urandom_range(225, 254));
            default: f[30:23] = 8'($urandom_range(110, 144));
        endcase
        return f;
    endfunction

    task automatic send_vector(input logic [127:0] v);
        int g;
        g = gap_length();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain_and_write(input logic [2:0] idx, input logic [63:0] val);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_matrix(input int mode);
        logic [63:0] v;
        for (int i = 0; i < 8; i++)
        begin
            case (mode)
                0: v = 64'hFFFF_FFFF_FFFF_FFFF;
                1: v = 64'h0;
                2: v = {32'h7F7F_FFFF, 32'h0080_0000};
                3: v = {32'hFF80_0000, 32'h0000_0001};
                default: v = {random_float(), random_float()};
            endcase
            drain_and_write(3'(i), v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && ($urandom_range(0, 99) < 70 || $urandom_range(0, 9) == 0);
    end

    initial
    begin
        hold_off = 1'b1;
        wait (rst_n);
        repeat (20) @(posedge clk);
        hold_off = 1'b0;
        wait (burst_phase);
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            hold_off = 1'b1;
            repeat ($urandom_range(1, 4) == 1 ? 60 : $urandom_range(1, 12)) @(posedge clk);
            hold_off = 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [127:0] v;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 3'd0;
        cfg_wdata = 64'd0;
        s_tvalid = 1'b0;
        s_tdata = 128'd0;
        burst_phase = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_vector({32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000});
        send_vector(128'd0);
        send_vector({4{32'h8000_0000}});
        send_vector({4{32'hFFFF_FFFF}});
        send_vector({32'h7F80_0000, 32'hFF80_0000, 32'h0, 32'h3F80_0000});
        send_vector({32'h7FA0_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF});
        send_vector({4{32'h7F7F_FFFF}});
        send_vector({32'h0000_0001, 32'h8000_0001, 32'h0080_0000, 32'h0000_0001});
        for (int m = 0; m < 4; m++)
        begin
            load_matrix(m);
            for (int k = 0; k < 4; k++)
                send_vector({random_float(), random_float(), random_float(), random_float()});
            send_vector({32'h3F80_0000, 32'hBF80_0000, 32'h0, 32'h7F80_0000});
        end
        for (int p = 0; p < 8; p++)
        begin
            load_matrix(4);
            burst_phase = 1'b1;
            for (int k = 0; k < 160; k++)
            begin
                v = {random_float(), random_float(), random_float(), random_float()};
                if ($urandom_range(0, 9) == 0)
                    v = {$urandom, $urandom, $urandom, $urandom};
                send_vector(v);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
